// ===== sv/ascii_range_record_parser_defines.svh =====
// Assertion macros for the ASCII range record parser.
// Used by the parser top level; needs clock and reset in the including scope.
`ifndef ASCII_RANGE_RECORD_PARSER_DEFINES_SVH
`define ASCII_RANGE_RECORD_PARSER_DEFINES_SVH

// Checked only outside reset.
`define ARRP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define ARRP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/arrp_pkg.sv =====
// Shared types and constants for the ASCII range record parser.
// No dependencies; used by the channel interfaces and the top level.
package arrp_pkg;

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_LF1   = 3'd1,
      PH_LF2   = 3'd2,
      PH_INT   = 3'd3,
      PH_FRAC1 = 3'd4,
      PH_FRAC2 = 3'd5
   } phase_type;

   localparam logic [7:0] CHAR_M    = 8'h6D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_DOT  = 8'h2E;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam int INT_W   = 10;
   localparam int RANGE_W = 16;

   localparam logic [INT_W-1:0]   INT_SAT   = 10'd655;
   localparam logic [RANGE_W-1:0] RANGE_SAT = 16'hFFFF;

   typedef logic [7:0]         byte_type;
   typedef logic [INT_W-1:0]   int_part_type;
   typedef logic [3:0]         digit_type;
   typedef logic [RANGE_W-1:0] range_type;

endpackage

// ===== sv/arrp_ifs.sv =====
// Valid/ready channel interfaces for the ASCII range record parser.
// Depends on arrp_pkg for payload types.
interface arrp_req_if;
   logic               valid;
   logic               ready;
   arrp_pkg::byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface arrp_rsp_if;
   logic                valid;
   logic                ready;
   arrp_pkg::range_type range_hundredths;
   logic                valid_res;

   modport source (output valid, output range_hundredths, output valid_res, input ready);
   modport sink   (input valid, input range_hundredths, input valid_res, output ready);
endinterface

// ===== sv/ascii_range_record_parser.sv =====
// Top level of the ASCII range record parser: input register, parse logic, result register.
// Depends on arrp_pkg, arrp_ifs.sv and ascii_range_record_parser_defines.svh.
//
// Takes one ASCII byte per transfer on req_in and hunts for an 'm' marker, then expects two
// line feeds, any number of integer digits, a '.', and two fraction digits. The second
// fraction digit produces one rsp_out transfer with the range in hundredths of a metre
// (integer part saturates at 655, the total at 65535) and valid_res high. Any unexpected
// byte after the marker produces range 0 with valid_res low and is consumed; bytes while
// hunting produce nothing. Each byte passes through an input register and a result
// register before its result is valid on rsp_out, and one byte is taken every cycle
// unless a byte is held while rsp_out is stalled with a result waiting.
`include "ascii_range_record_parser_defines.svh"

module ascii_range_record_parser (
   input  logic       clock,
   input  logic       reset,
   arrp_req_if.sink   req_in,
   arrp_rsp_if.source rsp_out
);

   logic                   in_valid_ff, in_valid_in;
   arrp_pkg::byte_type     in_byte_ff,  in_byte_in;
   arrp_pkg::phase_type    phase_ff,    phase_in;
   arrp_pkg::int_part_type int_part_ff, int_part_in;
   arrp_pkg::digit_type    frac_ff,     frac_in;
   logic                   out_valid_ff, out_valid_in;
   arrp_pkg::range_type    range_ff,     range_in;
   logic                   res_ok_ff,    res_ok_in;

   logic                   advance;
   logic                   step;
   logic                   is_digit;
   arrp_pkg::digit_type    digit;
   logic [12:0]            int_acc;
   logic [16:0]            total;
   logic                   emit;
   logic                   emit_ok;

   assign advance = !out_valid_ff || rsp_out.ready;
   assign step    = in_valid_ff && advance;

   assign req_in.ready = !in_valid_ff || advance;

   assign is_digit = in_byte_ff inside {[arrp_pkg::CHAR_ZERO:arrp_pkg::CHAR_NINE]};
   assign digit    = 4'(in_byte_ff - arrp_pkg::CHAR_ZERO);
   assign int_acc  = 13'(int_part_ff) * 13'd10 + 13'(digit);
   assign total    = 17'(int_part_ff) * 17'd100 + 17'(frac_ff) * 17'd10 + 17'(digit);

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         case (phase_ff)
            arrp_pkg::PH_LF1:
               phase_in = (in_byte_ff == arrp_pkg::CHAR_LF) ? arrp_pkg::PH_LF2
                                                             : arrp_pkg::PH_HUNT;
            arrp_pkg::PH_LF2:
               phase_in = (in_byte_ff == arrp_pkg::CHAR_LF) ? arrp_pkg::PH_INT
                                                             : arrp_pkg::PH_HUNT;
            arrp_pkg::PH_INT: begin
               if (is_digit) begin
                  phase_in = arrp_pkg::PH_INT;
               end else if (in_byte_ff == arrp_pkg::CHAR_DOT) begin
                  phase_in = arrp_pkg::PH_FRAC1;
               end else begin
                  phase_in = arrp_pkg::PH_HUNT;
               end
            end
            arrp_pkg::PH_FRAC1:
               phase_in = is_digit ? arrp_pkg::PH_FRAC2 : arrp_pkg::PH_HUNT;
            arrp_pkg::PH_FRAC2:
               phase_in = arrp_pkg::PH_HUNT;
            default:
               phase_in = (in_byte_ff == arrp_pkg::CHAR_M) ? arrp_pkg::PH_LF1
                                                            : arrp_pkg::PH_HUNT;
         endcase
      end
   end

   // datapath and result
   always_comb begin
      int_part_in = int_part_ff;
      frac_in     = frac_ff;
      emit        = 1'b0;
      emit_ok     = 1'b0;
      if (step) begin
         case (phase_ff)
            arrp_pkg::PH_LF1,
            arrp_pkg::PH_LF2:
               emit = (in_byte_ff != arrp_pkg::CHAR_LF);
            arrp_pkg::PH_INT: begin
               if (is_digit) begin
                  int_part_in = (int_acc > 13'(arrp_pkg::INT_SAT)) ? arrp_pkg::INT_SAT
                                                                   : int_acc[9:0];
               end else if (in_byte_ff != arrp_pkg::CHAR_DOT) begin
                  emit = 1'b1;
               end
            end
            arrp_pkg::PH_FRAC1: begin
               if (is_digit) begin
                  frac_in = digit;
               end else begin
                  emit = 1'b1;
               end
            end
            arrp_pkg::PH_FRAC2: begin
               emit    = 1'b1;
               emit_ok = is_digit;
            end
            default: begin
               if (in_byte_ff == arrp_pkg::CHAR_M) begin
                  int_part_in = '0;
                  frac_in     = '0;
               end
            end
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_in.valid && req_in.ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_in.rx_byte;
      end else if (step) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      range_in     = range_ff;
      res_ok_in    = res_ok_ff;
      if (out_valid_ff && rsp_out.ready) begin
         out_valid_in = 1'b0;
      end
      if (emit) begin
         out_valid_in = 1'b1;
         res_ok_in    = emit_ok;
         if (!emit_ok) begin
            range_in = '0;
         end else if (total > 17'(arrp_pkg::RANGE_SAT)) begin
            range_in = arrp_pkg::RANGE_SAT;
         end else begin
            range_in = total[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= arrp_pkg::PH_HUNT;
         int_part_ff  <= '0;
         frac_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         int_part_ff  <= int_part_in;
         frac_ff      <= frac_in;
      end
      in_byte_ff <= in_byte_in;
      range_ff   <= range_in;
      res_ok_ff  <= res_ok_in;
   end

   assign rsp_out.valid            = out_valid_ff;
   assign rsp_out.range_hundredths = range_ff;
   assign rsp_out.valid_res        = res_ok_ff;

   `ARRP_ASSERT(a_result_from_byte, $rose(out_valid_ff) |-> $past(in_valid_ff),
                "result without a byte")
   `ARRP_ASSERT(a_abort_zero, (out_valid_ff && !res_ok_ff) |-> (range_ff == '0),
                "abort range not zero")
   `ARRP_ASSERT(a_in_hold,
                (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)),
                "input register lost byte")
   `ARRP_ASSERT(a_int_sat,
                (phase_ff == arrp_pkg::PH_INT) |-> (int_part_ff <= arrp_pkg::INT_SAT),
                "integer part over limit")
   `ARRP_ASSERT_ALWAYS(a_reset_hunt,
                       $past(reset) |-> (phase_ff == arrp_pkg::PH_HUNT && !out_valid_ff),
                       "not idle after reset")

endmodule

// ===== tb/sv/tb_ascii_range_record_parser.sv =====
// Self-checking testbench for ascii_range_record_parser: random and directed byte streams,
// with a predictor and a scoreboard in a class. Needs arrp_pkg, arrp_ifs.sv and the RTL.
module tb_ascii_range_record_parser;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int BYTES_PER_MIX = 235;

   typedef struct packed {
      arrp_pkg::range_type range_hundredths;
      logic                valid_res;
   } range_result_type;

   class range_record_board;
      arrp_pkg::phase_type    phase;
      arrp_pkg::int_part_type int_acc;
      arrp_pkg::digit_type    frac_tenths;
      range_result_type       expected_ranges[$];
      int                     errors;
      int                     bytes_noted;
      int                     good_records;
      int                     aborted_records;

      function new();
         phase = arrp_pkg::PH_HUNT;
         int_acc = '0;
         frac_tenths = '0;
         errors = 0;
         bytes_noted = 0;
         good_records = 0;
         aborted_records = 0;
      endfunction

      // Advances the parser state by one byte; returns 1 when the byte ends a record.
      function bit parse_byte(arrp_pkg::byte_type b, output range_result_type r);
         bit                  is_dig;
         arrp_pkg::digit_type d;
         int unsigned         acc;
         is_dig = (b >= arrp_pkg::CHAR_ZERO) && (b <= arrp_pkg::CHAR_NINE);
         d = arrp_pkg::digit_type'(b - arrp_pkg::CHAR_ZERO);
         r = '0;
         case (phase)
            arrp_pkg::PH_LF1: begin
               if (b != arrp_pkg::CHAR_LF) begin
                  phase = arrp_pkg::PH_HUNT;
                  return 1'b1;
               end
               phase = arrp_pkg::PH_LF2;
            end
            arrp_pkg::PH_LF2: begin
               if (b != arrp_pkg::CHAR_LF) begin
                  phase = arrp_pkg::PH_HUNT;
                  return 1'b1;
               end
               phase = arrp_pkg::PH_INT;
            end
            arrp_pkg::PH_INT: begin
               if (is_dig) begin
                  acc = int_acc * 10 + d;
                  int_acc = (acc > arrp_pkg::INT_SAT) ? arrp_pkg::INT_SAT
                                                      : arrp_pkg::int_part_type'(acc);
               end else if (b == arrp_pkg::CHAR_DOT) begin
                  phase = arrp_pkg::PH_FRAC1;
               end else begin
                  phase = arrp_pkg::PH_HUNT;
                  return 1'b1;
               end
            end
            arrp_pkg::PH_FRAC1: begin
               phase = is_dig ? arrp_pkg::PH_FRAC2 : arrp_pkg::PH_HUNT;
               if (!is_dig)
                  return 1'b1;
               frac_tenths = d;
            end
            arrp_pkg::PH_FRAC2: begin
               phase = arrp_pkg::PH_HUNT;
               if (!is_dig)
                  return 1'b1;
               acc = int_acc * 100 + frac_tenths * 10 + d;
               r.range_hundredths = (acc > arrp_pkg::RANGE_SAT) ? arrp_pkg::RANGE_SAT
                                                                : arrp_pkg::range_type'(acc);
               r.valid_res = 1'b1;
               return 1'b1;
            end
            default: begin
               if (b == arrp_pkg::CHAR_M) begin
                  int_acc = '0;
                  frac_tenths = '0;
                  phase = arrp_pkg::PH_LF1;
               end else begin
                  phase = arrp_pkg::PH_HUNT;
               end
            end
         endcase
         return 1'b0;
      endfunction

      function void note_byte(arrp_pkg::byte_type b);
         range_result_type r;
         bytes_noted++;
         if (parse_byte(b, r))
            expected_ranges = {expected_ranges, r};
      endfunction

      function void check_range(arrp_pkg::range_type range_hundredths, logic valid_res);
         range_result_type exp_r;
         if (expected_ranges.size() == 0) begin
            $error("result with nothing expected: range_hundredths %0d valid_res %0b",
                   range_hundredths, valid_res);
            errors++;
            return;
         end
         exp_r = expected_ranges.pop_front();
         if (valid_res)
            good_records++;
         else
            aborted_records++;
         if (range_hundredths !== exp_r.range_hundredths) begin
            $error("range_hundredths: expected %0d, got %0d",
                   exp_r.range_hundredths, range_hundredths);
            errors++;
         end
         if (valid_res !== exp_r.valid_res) begin
            $error("valid_res: expected %0b, got %0b", exp_r.valid_res, valid_res);
            errors++;
         end
      endfunction

      function int pending();
         return expected_ranges.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   rsp_idle_pct;
   int   quiet_cycles;

   range_record_board board = new();

   arrp_req_if req_in();
   arrp_rsp_if rsp_out();

   ascii_range_record_parser uut (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_in),
      .rsp_out (rsp_out)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_out.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_out.valid && rsp_out.ready)
         board.check_range(rsp_out.range_hundredths, rsp_out.valid_res);
   end

   always @(posedge clock) begin
      if (reset || (req_in.valid && req_in.ready) || (rsp_out.valid && rsp_out.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("FAIL ascii_range_record_parser");
         $finish;
      end
   end

   task automatic send_byte(input arrp_pkg::byte_type b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_in.valid <= 1'b0;
         @(posedge clock);
      end
      req_in.valid <= 1'b1;
      req_in.rx_byte <= b;
      do
         @(posedge clock);
      while (!req_in.ready);
      board.note_byte(b);
   endtask

   task automatic send_string(input arrp_pkg::byte_type seq[$]);
      foreach (seq[i])
         send_byte(seq[i]);
   endtask

   // Holds the sender off until every pending result has been transferred.
   task automatic drain_results();
      req_in.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   task automatic send_random_record(input bit broken);
      arrp_pkg::byte_type rec[$];
      int                 n_int;
      int                 pos;
      rec = {arrp_pkg::CHAR_M, arrp_pkg::CHAR_LF, arrp_pkg::CHAR_LF};
      n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
      repeat (n_int)
         rec = {rec, 8'(arrp_pkg::CHAR_ZERO + $urandom_range(0, 9))};
      rec = {rec, arrp_pkg::CHAR_DOT};
      repeat (2)
         rec = {rec, 8'(arrp_pkg::CHAR_ZERO + $urandom_range(0, 9))};
      if (broken) begin
         pos = $urandom_range(1, rec.size() - 1);
         rec[pos] = 8'($urandom_range(0, 255));
      end
      send_string(rec);
   endtask

   task automatic run_random_mix(input int snd_pct, input int rcv_pct);
      int start_count;
      int kind;
      send_idle_pct = snd_pct;
      rsp_idle_pct = rcv_pct;
      start_count = board.bytes_noted;
      while (board.bytes_noted - start_count < BYTES_PER_MIX) begin
         kind = $urandom_range(0, 99);
         if (kind < 70)
            send_random_record(1'b0);
         else if (kind < 85)
            send_random_record(1'b1);
         else
            repeat ($urandom_range(1, 4))
               send_byte(8'($urandom_range(0, 255)));
      end
      drain_results();
   endtask

   initial begin
      reset = 1'b1;
      req_in.valid = 1'b0;
      req_in.rx_byte = '0;
      rsp_out.ready = 1'b0;
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      quiet_cycles = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // noise while hunting, empty integer part, marker inside a record,
      // integer and total saturation
      send_string({8'h00, 8'hFF});
      send_string({arrp_pkg::CHAR_M, arrp_pkg::CHAR_LF, arrp_pkg::CHAR_LF,
                   arrp_pkg::CHAR_DOT, arrp_pkg::CHAR_ZERO, arrp_pkg::CHAR_ZERO});
      send_string({arrp_pkg::CHAR_M, arrp_pkg::CHAR_M});
      send_string({arrp_pkg::CHAR_M, arrp_pkg::CHAR_LF, arrp_pkg::CHAR_LF,
                   arrp_pkg::CHAR_NINE, arrp_pkg::CHAR_NINE, arrp_pkg::CHAR_NINE,
                   arrp_pkg::CHAR_DOT, arrp_pkg::CHAR_NINE, arrp_pkg::CHAR_NINE});
      drain_results();

      run_random_mix(38, 60);
      run_random_mix(60, 38);
      run_random_mix(0, 0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d bytes; checked %0d parsed and %0d aborted records",
               board.bytes_noted, board.good_records, board.aborted_records);
      $display("under three sender/receiver stall mixes with a full drain between them.");
      if (board.errors == 0 && board.pending() == 0)
         $display("PASS ascii_range_record_parser");
      else
         $display("FAIL ascii_range_record_parser");
      $finish;
   end
endmodule
